// File: hdl/shsc_pkg.sv
`default_nettype none
package shsc_pkg;

  // code geometry at the largest parity count
  localparam int MAX_PARITY = 6;
  localparam int MIN_PARITY = 2;
  localparam int WORD_W     = (1 << MAX_PARITY) - 1;
  localparam int KMAX       = WORD_W - MAX_PARITY;
  localparam int LEN_W      = $clog2(WORD_W + 1);
  localparam int M_W        = 3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY = 1'b1;
  localparam logic                 MODE_ENC   = 1'b0;
  localparam logic                 MODE_DEC   = 1'b1;
  localparam logic [M_W-1:0]       PARITY_RST = 3'd3;

  // input queue depth
  localparam int QDEPTH = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KMAX-1:0][MAX_PARITY-1:0] col_tab_t;

  // configuration seen by the back units
  typedef struct packed {
    logic           mode;
    logic [M_W-1:0] m;
  } cfg_t;

  // classified input word held in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] nbits;
    logic       last;
  } ent_t;

  // assembled codeword (or step end marker) from the assembler
  typedef struct packed {
    logic  has_word;
    word_t word;
    logic  end_step;
    logic  step_last;
  } wmsg_t;

  // coded bits, first bit at the top, for the packer
  typedef struct packed {
    logic             has_word;
    word_t            code;
    logic [LEN_W-1:0] len;
    logic             err;
    logic             end_step;
    logic             step_last;
  } cmsg_t;

  // clamp the parity count to the supported range
  function automatic logic [M_W-1:0] eff_m(input logic [M_W-1:0] p);
    logic [M_W-1:0] r;
    r = p;
    if (p < M_W'(MIN_PARITY)) r = M_W'(MIN_PARITY);
    else if (p > M_W'(MAX_PARITY)) r = M_W'(MAX_PARITY);
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] code_n(input logic [M_W-1:0] m);
    return LEN_W'((1 << m) - 1);
  endfunction

  function automatic logic [LEN_W-1:0] code_k(input logic [M_W-1:0] m);
    return code_n(m) - LEN_W'(m);
  endfunction

  // data columns: the non power-of-two values in rising order
  function automatic col_tab_t make_cols();
    col_tab_t t;
    int       cnt;
    t   = '0;
    cnt = 0;
    for (int v = 3; v <= WORD_W; v++) begin
      if ((v & (v - 1)) != 0) begin
        if (cnt < KMAX) t[cnt] = MAX_PARITY'(v);
        cnt++;
      end
    end
    return t;
  endfunction

  localparam col_tab_t DATA_COLS = make_cols();

endpackage
`default_nettype wire

// File: hdl/shsc_in_if.sv
`default_nettype none
interface shsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic [3:0] last_valid_bits;

  modport source (output valid, data_byte, last, last_valid_bits, input ready);
  modport sink   (input valid, data_byte, last, last_valid_bits, output ready);
endinterface
`default_nettype wire

// File: hdl/shsc_out_if.sv
`default_nettype none
interface shsc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] corrected_words;
  logic [23:0] bit_total;

  modport source (output valid, out_byte, out_last, corrected_words, bit_total, input ready);
  modport sink   (input valid, out_byte, out_last, corrected_words, bit_total, output ready);
endinterface
`default_nettype wire

// File: hdl/shsc_cfg_if.sv
`default_nettype none
interface shsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [shsc_pkg::CFG_IDX_W-1:0]  index;
  logic [shsc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/systematic_hamming_stream_codec_core.sv
`default_nettype none
// Streaming systematic Hamming single-error-correcting codec. Words (bytes) enter on
// in_ch most significant bit first; with m parity bits (cfg register 1, clamped to
// 2..6) codewords are 2^m-1 bits, data first then parity. Mode 0 (cfg register 0)
// encodes k = 2^m-1-m data bits per codeword and pads the final codeword with zeros;
// mode 1 corrects a single bit error per codeword, sends the k data bits, drops a
// trailing partial codeword and counts corrected codewords. Output bits are packed
// into words on out_ch; the final word of a buffer is zero padded and carries out_last.
// corrected_words and bit_total saturate and clear after each final word. Write
// configuration only while idle: a write discards any partial codeword and pending bits.
// Timing: input words land in a four-entry queue, then the assembler takes each word one
// slice at a time, a slice ending at a codeword boundary or at the word's end, and waits
// while its output slot is full; the packer moves a codeword one slice at a time, each
// slice filling or closing an output word, and closes each input word in a step of its own.
// With m = 2 every data bit is a codeword and the packer sets the pace of encoding.
module systematic_hamming_stream_codec_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  shsc_cfg_if.sink   cfg_ch,
  shsc_in_if.sink    in_ch,
  shsc_out_if.source out_ch
);
  import shsc_pkg::*;

  logic           mode_r;
  logic [M_W-1:0] par_r;
  logic           clr;
  cfg_t           cfg;
  ent_t           hd;
  logic           hd_valid, hd_ready;
  wmsg_t          wm;
  logic           wm_valid, wm_ready;
  cmsg_t          cm;
  logic           cm_valid, cm_ready;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  assign clr          = cfg_ch.valid;
  assign cfg.mode     = mode_r;
  assign cfg.m        = eff_m(par_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      par_r  <= PARITY_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MODE:   mode_r <= cfg_ch.data[0];
        CFG_PARITY: par_r  <= cfg_ch.data;
        default:    mode_r <= mode_r;
      endcase
    end
  end

  // front: classify and queue input words
  shsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .mode     (mode_r),
    .hd       (hd),
    .hd_valid (hd_valid),
    .hd_ready (hd_ready)
  );

  // back: assemble codewords
  shsc_asm u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .cfg      (cfg),
    .hd       (hd),
    .hd_valid (hd_valid),
    .hd_ready (hd_ready),
    .wm       (wm),
    .wm_valid (wm_valid),
    .wm_ready (wm_ready)
  );

  // back: encode or correct
  shsc_coder u_coder (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .wm       (wm),
    .wm_valid (wm_valid),
    .wm_ready (wm_ready),
    .cm       (cm),
    .cm_valid (cm_valid),
    .cm_ready (cm_ready)
  );

  // back: pack bits into output words
  shsc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .cm       (cm),
    .cm_valid (cm_valid),
    .cm_ready (cm_ready),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// File: hdl/shsc_front.sv
`default_nettype none
module shsc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  shsc_in_if.sink             in_ch,
  input  wire logic           mode,
  output shsc_pkg::ent_t      hd,
  output logic                hd_valid,
  input  wire logic           hd_ready
);
  import shsc_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  ent_t             q_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ent_t             ent;
  logic             push, pop;

  // classify: how many leading bits of the word are used
  always_comb begin
    ent.data_byte = in_ch.data_byte;
    ent.last      = in_ch.last;
    ent.nbits     = 4'd8;
    if (in_ch.last && mode == MODE_DEC) begin
      ent.nbits = (in_ch.last_valid_bits > 4'd8) ? 4'd8 : in_ch.last_valid_bits;
    end
  end

  // queue handshakes
  assign in_ch.ready = (cnt_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign hd_valid    = (cnt_r != '0);
  assign pop         = hd_valid && hd_ready;
  assign hd          = q_mem[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= ent;
  end

endmodule
`default_nettype wire

// File: hdl/shsc_asm.sv
`default_nettype none
module shsc_asm (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           clr,
  input  wire shsc_pkg::cfg_t cfg,
  input  wire shsc_pkg::ent_t hd,
  input  wire logic           hd_valid,
  output logic                hd_ready,
  output shsc_pkg::wmsg_t     wm,
  output logic                wm_valid,
  input  wire logic           wm_ready
);
  import shsc_pkg::*;

  word_t            word_r, word_nxt, word_ins;
  logic [LEN_W-1:0] fill_r, fill_nxt, len_w, need;
  logic [LEN_W:0]   fsum;
  logic [3:0]       pos_r, pos_nxt, r, c;
  logic [7:0]       bsh, brev;
  logic [8:0]       cmask;
  logic             completes, fin, send, flush_pad, slot_free, step_ok;
  wmsg_t            wm_r, wm_nxt;
  logic             wm_valid_r, wm_valid_nxt;

  assign wm       = wm_r;
  assign wm_valid = wm_valid_r;

  // slice of the current word that fits the open codeword
  always_comb begin
    len_w = (cfg.mode == MODE_DEC) ? code_n(cfg.m) : code_k(cfg.m);
    r     = hd.nbits - pos_r;
    need  = len_w - fill_r;
    c     = (need < LEN_W'(r)) ? need[3:0] : r;
    bsh   = hd.data_byte << pos_r;
    for (int j = 0; j < 8; j++) brev[j] = bsh[7-j];
    cmask    = (9'd1 << c) - 9'd1;
    word_ins = word_r | (word_t'(brev & cmask[7:0]) << fill_r);
    fsum     = {1'b0, fill_r} + (LEN_W+1)'(c);
  end

  // codeword completion and step end
  always_comb begin
    completes = (fsum == {1'b0, len_w});
    fin       = (c == r);
    flush_pad = fin && hd.last && cfg.mode == MODE_ENC && fsum != '0;
    send      = completes || fin;
    slot_free = !wm_valid_r || wm_ready;
    step_ok   = hd_valid && (!send || slot_free);
    hd_ready  = step_ok && fin;
  end

  // next state
  always_comb begin
    word_nxt     = word_r;
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    wm_nxt       = wm_r;
    wm_valid_nxt = wm_valid_r;
    if (wm_ready) wm_valid_nxt = 1'b0;
    if (step_ok) begin
      pos_nxt = fin ? 4'd0 : pos_r + c;
      if (completes || (fin && hd.last)) begin
        word_nxt = '0;
        fill_nxt = '0;
      end else begin
        word_nxt = word_ins;
        fill_nxt = fsum[LEN_W-1:0];
      end
      if (send) begin
        wm_valid_nxt     = 1'b1;
        wm_nxt.has_word  = completes || flush_pad;
        wm_nxt.word      = word_ins;
        wm_nxt.end_step  = fin;
        wm_nxt.step_last = hd.last;
      end
    end
    if (clr) begin
      word_nxt = '0;
      fill_nxt = '0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r     <= '0;
      fill_r     <= '0;
      pos_r      <= '0;
      wm_valid_r <= 1'b0;
    end else begin
      word_r     <= word_nxt;
      fill_r     <= fill_nxt;
      pos_r      <= pos_nxt;
      wm_valid_r <= wm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wm_r <= wm_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/shsc_coder.sv
`default_nettype none
module shsc_coder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire shsc_pkg::cfg_t  cfg,
  input  wire shsc_pkg::wmsg_t wm,
  input  wire logic            wm_valid,
  output logic                 wm_ready,
  output shsc_pkg::cmsg_t      cm,
  output logic                 cm_valid,
  input  wire logic            cm_ready
);
  import shsc_pkg::*;

  logic [LEN_W-1:0]      k, n;
  logic [MAX_PARITY-1:0] dsyn, pbits, pbr, par, syn, idx;
  logic [M_W-1:0]        hb;
  word_t                 flip, dword, drev, kmask, ppos;
  logic                  syn_nz, syn_pow;
  cmsg_t                 cm_r, cm_nxt;
  logic                  cm_valid_r;

  assign cm       = cm_r;
  assign cm_valid = cm_valid_r;
  assign wm_ready = !cm_valid_r || cm_ready;

  // syndrome from the data columns and, when decoding, the received parity
  always_comb begin
    k    = code_k(cfg.m);
    n    = code_n(cfg.m);
    dsyn = '0;
    for (int i = 0; i < KMAX; i++) begin
      if (wm.word[i] && (LEN_W'(i) < k)) dsyn = dsyn ^ DATA_COLS[i];
    end
    pbits = MAX_PARITY'(wm.word >> k);
    for (int j = 0; j < MAX_PARITY; j++) pbr[MAX_PARITY-1-j] = pbits[j];
    par = pbr >> (M_W'(MAX_PARITY) - cfg.m);
    syn = (cfg.mode == MODE_DEC) ? (dsyn ^ par) : dsyn;
  end

  // locate the data bit whose column matches the syndrome
  always_comb begin
    hb = '0;
    for (int i = 0; i < MAX_PARITY; i++) begin
      if (syn[i]) hb = M_W'(i);
    end
    idx     = syn - MAX_PARITY'(2) - MAX_PARITY'(hb);
    syn_nz  = (syn != '0);
    syn_pow = ((syn & (syn - 1'b1)) == '0);
    flip    = (cfg.mode == MODE_DEC && syn_nz && !syn_pow) ? (word_t'(1) << idx) : '0;
    dword   = wm.word ^ flip;
    for (int i = 0; i < WORD_W; i++) drev[WORD_W-1-i] = dword[i];
    kmask   = ~({WORD_W{1'b1}} >> k);
    ppos    = word_t'(syn) << (LEN_W'(WORD_W) - n);
  end

  // build the outgoing bits, first bit at the top
  always_comb begin
    cm_nxt.has_word  = wm.has_word;
    cm_nxt.code      = (drev & kmask) | ((cfg.mode == MODE_ENC) ? ppos : '0);
    cm_nxt.len       = (cfg.mode == MODE_DEC) ? k : n;
    cm_nxt.err       = wm.has_word && cfg.mode == MODE_DEC && syn_nz;
    cm_nxt.end_step  = wm.end_step;
    cm_nxt.step_last = wm.step_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_valid_r <= 1'b0;
    end else if (wm_ready) begin
      cm_valid_r <= wm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wm_valid && wm_ready) cm_r <= cm_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/shsc_pack.sv
`default_nettype none
module shsc_pack (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            clr,
  input  wire shsc_pkg::cmsg_t cm,
  input  wire logic            cm_valid,
  output logic                 cm_ready,
  shsc_out_if.source           out_ch
);
  import shsc_pkg::*;

  logic             busy_r, busy_nxt;
  word_t            code_r, code_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             endf_r, endf_nxt, lastf_r, lastf_nxt;
  logic [6:0]       pend_r, pend_nxt;
  logic [2:0]       pcnt_r, pcnt_nxt;
  logic [15:0]      tally_r, tally_nxt;
  logic [23:0]      total_r, total_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [7:0]       hold_byte_r, hold_byte_nxt;
  logic [15:0]      hold_tally_r, hold_tally_nxt;
  logic [23:0]      hold_total_r, hold_total_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic [15:0]      ot_r, ot_nxt;
  logic [23:0]      obt_r, obt_nxt;

  logic [3:0]       space, t;
  logic [14:0]      mix;
  logic [7:0]       flush;
  logic [24:0]      sum;
  logic             full, out_free, fin, push, push_last;

  assign out_ch.valid           = ov_r;
  assign out_ch.out_byte        = ob_r;
  assign out_ch.out_last        = ol_r;
  assign out_ch.corrected_words = ot_r;
  assign out_ch.bit_total       = obt_r;

  // bits that fit the pending byte this cycle
  always_comb begin
    space    = 4'd8 - {1'b0, pcnt_r};
    t        = (rem_r < LEN_W'(space)) ? rem_r[3:0] : space;
    mix      = {pend_r, code_r[WORD_W-1 -: 8]} >> (4'd8 - t);
    full     = ({1'b0, pcnt_r} + t) == 4'd8;
    sum      = {1'b0, total_r} + 25'(t);
    flush    = {1'b0, pend_r} << (4'd8 - {1'b0, pcnt_r});
    out_free = !ov_r || out_ch.ready;
  end

  // packing sequencer with one byte held back to mark the end of a step
  always_comb begin
    busy_nxt       = busy_r;
    code_nxt       = code_r;
    rem_nxt        = rem_r;
    endf_nxt       = endf_r;
    lastf_nxt      = lastf_r;
    pend_nxt       = pend_r;
    pcnt_nxt       = pcnt_r;
    tally_nxt      = tally_r;
    total_nxt      = total_r;
    hold_v_nxt     = hold_v_r;
    hold_byte_nxt  = hold_byte_r;
    hold_tally_nxt = hold_tally_r;
    hold_total_nxt = hold_total_r;
    ov_nxt         = ov_r;
    ob_nxt         = ob_r;
    ol_nxt         = ol_r;
    ot_nxt         = ot_r;
    obt_nxt        = obt_r;
    fin            = 1'b0;
    push           = 1'b0;
    push_last      = 1'b0;
    if (out_ch.ready) ov_nxt = 1'b0;

    if (busy_r) begin
      if (rem_r != '0) begin
        // move a slice of the codeword into the pending byte
        if (!full || !hold_v_r || out_free) begin
          code_nxt  = code_r << t;
          rem_nxt   = rem_r - LEN_W'(t);
          total_nxt = sum[24] ? '1 : sum[23:0];
          if (full) begin
            push           = hold_v_r;
            hold_v_nxt     = 1'b1;
            hold_byte_nxt  = mix[7:0];
            hold_tally_nxt = tally_r;
            hold_total_nxt = total_nxt;
            pend_nxt       = '0;
            pcnt_nxt       = '0;
          end else begin
            pend_nxt = mix[6:0];
            pcnt_nxt = pcnt_r + 3'(t);
          end
          if (rem_r == LEN_W'(t) && !endf_r) begin
            fin      = 1'b1;
            busy_nxt = 1'b0;
          end
        end
      end else if (endf_r && lastf_r && pcnt_r != '0) begin
        // zero-padded final byte
        if (!hold_v_r || out_free) begin
          push           = hold_v_r;
          hold_v_nxt     = 1'b1;
          hold_byte_nxt  = flush;
          hold_tally_nxt = tally_r;
          hold_total_nxt = total_r;
          pend_nxt       = '0;
          pcnt_nxt       = '0;
        end
      end else if (endf_r) begin
        // step closes: release the held byte, tagged last on a final word
        if (!hold_v_r || out_free) begin
          push       = hold_v_r;
          push_last  = lastf_r;
          hold_v_nxt = 1'b0;
          fin        = 1'b1;
          busy_nxt   = 1'b0;
          if (lastf_r) begin
            tally_nxt = '0;
            total_nxt = '0;
          end
        end
      end else begin
        fin      = 1'b1;
        busy_nxt = 1'b0;
      end
    end

    if (push) begin
      ov_nxt  = 1'b1;
      ob_nxt  = hold_byte_r;
      ol_nxt  = push_last;
      ot_nxt  = hold_tally_r;
      obt_nxt = hold_total_r;
    end

    cm_ready = !busy_r || fin;
    if (cm_valid && cm_ready) begin
      busy_nxt  = 1'b1;
      code_nxt  = cm.code;
      rem_nxt   = cm.has_word ? cm.len : '0;
      endf_nxt  = cm.end_step;
      lastf_nxt = cm.step_last;
      if (cm.err && tally_nxt != '1) tally_nxt = tally_nxt + 1'b1;
    end

    if (clr) begin
      pend_nxt = '0;
      pcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pend_r   <= '0;
      pcnt_r   <= '0;
      tally_r  <= '0;
      total_r  <= '0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      pend_r   <= pend_nxt;
      pcnt_r   <= pcnt_nxt;
      tally_r  <= tally_nxt;
      total_r  <= total_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    rem_r        <= rem_nxt;
    endf_r       <= endf_nxt;
    lastf_r      <= lastf_nxt;
    hold_byte_r  <= hold_byte_nxt;
    hold_tally_r <= hold_tally_nxt;
    hold_total_r <= hold_total_nxt;
    ob_r         <= ob_nxt;
    ol_r         <= ol_nxt;
    ot_r         <= ot_nxt;
    obt_r        <= obt_nxt;
  end

endmodule
`default_nettype wire

// File: verif/shsc_stream_checker.sv
`default_nettype none
module shsc_stream_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  shsc_cfg_if       cfg_mon,
  shsc_in_if        in_mon,
  shsc_out_if       out_mon,
  output int        fail_count,
  output int        words_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import shsc_pkg::*;

  // one predicted output word
  typedef struct {
    logic [7:0]  val;
    logic        fin;
    logic [15:0] fixed;
    logic [23:0] nbits;
  } out_word_t;

  out_word_t   owed_words[$];

  // shadow of the codec state
  logic        mode_r;
  logic [2:0]  parity_r;
  logic [62:0] word_acc;
  int          word_got;
  logic [7:0]  pack_acc;
  int          pack_cnt;
  logic [15:0] fix_tally;
  logic [23:0] bit_tally;
  int          errs;

  function automatic int clamp_m(input logic [2:0] p);
    if (p < MIN_PARITY) return MIN_PARITY;
    if (p > MAX_PARITY) return MAX_PARITY;
    return int'(p);
  endfunction

  // xor of the data columns picked by the k data bits, first bit at the top
  function automatic logic [5:0] column_xor(input logic [63:0] data, input int k);
    int         v;
    logic [5:0] acc;
    v   = 1;
    acc = '0;
    for (int i = 0; i < k; i++) begin
      v++;
      while ((v & (v - 1)) == 0) v++;
      if (data[k-1-i]) acc ^= 6'(v);
    end
    return acc;
  endfunction

  function automatic void clear_word_state();
    word_acc = '0;
    word_got = 0;
    pack_acc = '0;
    pack_cnt = 0;
  endfunction

  task automatic put_out_bit(input logic b);
    if (bit_tally != 24'hFFFFFF) bit_tally++;
    pack_acc = {pack_acc[6:0], b};
    pack_cnt++;
    if (pack_cnt == 8) begin
      owed_words.push_back('{pack_acc, 1'b0, fix_tally, bit_tally});
      pack_acc = '0;
      pack_cnt = 0;
    end
  endtask

  // encode or correct the gathered codeword and send its bits
  task automatic close_word();
    int          m, n, k, idx;
    logic [63:0] data, code;
    logic [5:0]  syn;
    m = clamp_m(parity_r);
    n = (1 << m) - 1;
    k = n - m;
    if (mode_r == MODE_DEC) begin
      data = (64'(word_acc) >> m) & ((64'd1 << k) - 64'd1);
      syn  = column_xor(data, k) ^ (6'(word_acc) & 6'((1 << m) - 1));
      if (syn != 0) begin
        if (fix_tally != 16'hFFFF) fix_tally++;
        // a parity column leaves the data alone
        if ((syn & (syn - 1)) != 0) begin
          idx = 0;
          for (int v = 3; v < syn; v++) if ((v & (v - 1)) != 0) idx++;
          data[k-1-idx] = ~data[k-1-idx];
        end
      end
      for (int j = 0; j < k; j++) put_out_bit(data[k-1-j]);
    end else begin
      data = 64'(word_acc) & ((64'd1 << k) - 64'd1);
      code = (data << m) | 64'(column_xor(data, k));
      for (int j = 0; j < n; j++) put_out_bit(code[n-1-j]);
    end
    word_acc = '0;
    word_got = 0;
  endtask

  task automatic take_in_bit(input logic b);
    int m, len;
    m   = clamp_m(parity_r);
    len = (mode_r == MODE_DEC) ? (1 << m) - 1 : (1 << m) - 1 - m;
    word_acc = {word_acc[61:0], b};
    word_got++;
    if (word_got >= len) close_word();
  endtask

  // work out every output word caused by one input word
  task automatic absorb_input(input logic [7:0] b, input logic lst, input logic [3:0] lvb);
    int          nb, k, before_cnt;
    logic [7:0]  padded;
    out_word_t   tail;
    before_cnt = owed_words.size();
    nb = 8;
    if (lst && mode_r == MODE_DEC) nb = (lvb > 4'd8) ? 8 : int'(lvb);
    for (int i = 0; i < nb; i++) take_in_bit(b[7-i]);
    if (lst) begin
      // flush: pad a partial data word when encoding, drop it when decoding
      if (mode_r == MODE_ENC && word_got > 0) begin
        k = (1 << clamp_m(parity_r)) - 1 - clamp_m(parity_r);
        if (word_got < k) word_acc = word_acc << (k - word_got);
        close_word();
      end
      if (pack_cnt > 0) begin
        padded = pack_acc << (8 - pack_cnt);
        owed_words.push_back('{padded, 1'b0, fix_tally, bit_tally});
      end
      if (owed_words.size() > before_cnt) begin
        tail = owed_words.pop_back();
        tail.fin = 1'b1;
        owed_words.push_back(tail);
      end
      clear_word_state();
      fix_tally = '0;
      bit_tally = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      mode_r    = MODE_ENC;
      parity_r  = PARITY_RST;
      fix_tally = '0;
      bit_tally = '0;
      errs      = 0;
      clear_word_state();
      owed_words.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_MODE) mode_r = cfg_mon.data[0];
        else parity_r = cfg_mon.data;
        clear_word_state();
      end
      if (in_mon.valid && in_mon.ready)
        absorb_input(in_mon.data_byte, in_mon.last, in_mon.last_valid_bits);
      if (out_mon.valid && out_mon.ready) begin
        if (owed_words.size() == 0) begin
          errs++;
          $display("%0t: output word %0h with nothing expected", $time, out_mon.out_byte);
        end else begin
          want = owed_words.pop_front();
          check_field("out_byte", 24'(want.val), 24'(out_mon.out_byte));
          check_field("out_last", 24'(want.fin), 24'(out_mon.out_last));
          check_field("corrected_words", 24'(want.fixed), 24'(out_mon.corrected_words));
          check_field("bit_total", want.nbits, out_mon.bit_total);
        end
      end
    end
    fail_count <= errs;
    words_owed <= owed_words.size();
  end

endmodule
`default_nettype wire

// File: verif/systematic_hamming_stream_codec_core_tb.sv
`default_nettype none
module systematic_hamming_stream_codec_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shsc_pkg::*;

  localparam int ITEMS_TARGET = 420;
  localparam int SETTLE_TAIL  = 150;
  localparam int CYCLE_LIMIT  = 600000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        sink_ready = 1'b0;
  int          sink_hold  = 0;
  int          fails;
  int          owed;
  int unsigned cyc = 0;
  bit          gaps_on  = 1'b1;
  bit          stall_on = 1'b1;
  int          sent = 0;
  logic        cur_mode = MODE_ENC;
  logic [2:0]  cur_par  = PARITY_RST;
  bit          code_bits[$];

  shsc_cfg_if cfg_ch();
  shsc_in_if  in_ch();
  shsc_out_if out_ch();

  systematic_hamming_stream_codec_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  shsc_stream_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_mon    (cfg_ch),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fails),
    .words_owed (owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output side: random stall after each accepted word
  assign out_ch.ready = sink_ready;
  always @(posedge clk) begin : sink
    int draw;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      sink_hold  <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      draw = stall_on ? $urandom_range(0, 7) : 0;
      sink_hold  <= draw;
      sink_ready <= (draw == 0);
    end else if (sink_hold != 0) begin
      sink_hold  <= sink_hold - 1;
      sink_ready <= (sink_hold == 1);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic lst, input logic [3:0] lvb);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.data_byte       <= b;
    in_ch.last            <= lst;
    in_ch.last_valid_bits <= lvb;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // hold input off until no output word is owed, then let the pipe drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input bit do_mode, input bit do_par, input logic md,
                            input logic [2:0] pm);
    bit par_first;
    par_first = $urandom_range(0, 1);
    if (do_par && par_first) write_reg(CFG_PARITY, pm);
    if (do_mode) write_reg(CFG_MODE, {2'($urandom_range(0, 3)), md});
    if (do_par && !par_first) write_reg(CFG_PARITY, pm);
    cfg_ch.valid <= 1'b0;
    if (do_mode) cur_mode = md;
    if (do_par) cur_par = pm;
  endtask

  // check bits for building decoder stimulus
  function automatic logic [5:0] code_checks(input logic [63:0] d, input int k);
    int         v;
    logic [5:0] acc;
    v   = 1;
    acc = '0;
    for (int i = 0; i < k; i++) begin
      v++;
      while ((v & (v - 1)) == 0) v++;
      if (d[k-1-i]) acc ^= 6'(v);
    end
    return acc;
  endfunction

  // append one codeword, flip < 0 leaves it clean
  task automatic add_codeword(input int m, input logic [63:0] d, input int flip);
    int          n, k;
    logic [63:0] cw;
    n  = (1 << m) - 1;
    k  = n - m;
    d  = d & ((64'd1 << k) - 64'd1);
    cw = (d << m) | 64'(code_checks(d, k));
    if (flip >= 0) cw[n-1-flip] = ~cw[n-1-flip];
    for (int j = 0; j < n; j++) code_bits.push_back(cw[n-1-j]);
  endtask

  // pack the queued code bits into words, unused low bits random
  task automatic send_code_bits(input bit close);
    logic [7:0] b;
    int         cnt;
    while (code_bits.size() > 0) begin
      cnt = (code_bits.size() > 8) ? 8 : code_bits.size();
      b   = 8'($urandom);
      for (int j = 0; j < cnt; j++) b[7-j] = code_bits.pop_front();
      if (code_bits.size() == 0 && close) push_word(b, 1'b1, 4'(cnt));
      else push_word(b, 1'b0, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_buffer();
    int m, n, nb, nw, flip;
    bit close;
    m = (cur_par < MIN_PARITY) ? MIN_PARITY : (cur_par > MAX_PARITY) ? MAX_PARITY : cur_par;
    n = (1 << m) - 1;
    close = ($urandom_range(0, 5) != 0);
    if (cur_mode == MODE_ENC || $urandom_range(0, 3) == 0) begin
      // raw words: payload when encoding, noise when decoding
      nb = $urandom_range(1, 10);
      for (int i = 0; i < nb; i++)
        push_word(8'($urandom), close && (i == nb - 1), 4'($urandom_range(0, 15)));
    end else begin
      nw = (m >= 5) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      for (int i = 0; i < nw; i++) begin
        flip = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, n - 1);
        add_codeword(m, {$urandom, $urandom}, flip);
      end
      // trailing partial codeword, dropped by the decoder
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, n - 1)) code_bits.push_back($urandom_range(0, 1));
      send_code_bits(close);
    end
  endtask

  initial begin : stim
    int         plan[8];
    int         phase;
    logic       md;
    logic [2:0] pm;
    bit         one_only;
    plan = '{2, 6, 7, 0, 1, 3, 4, 5};
    in_ch.valid           <= 1'b0;
    in_ch.data_byte       <= '0;
    in_ch.last            <= 1'b0;
    in_ch.last_valid_bits <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_MODE;
    cfg_ch.data           <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: encode with three parity bits
    push_word(8'h00, 1'b0, 4'h0);
    push_word(8'hFF, 1'b0, 4'hF);
    push_word(8'hA5, 1'b1, 4'h8);
    settle();

    // parity count below range acts as two
    set_config(1'b1, 1'b1, MODE_ENC, 3'd0);
    push_word(8'hFF, 1'b0, 4'h3);
    push_word(8'h5A, 1'b1, 4'h1);
    settle();

    // parity count above range acts as six, short word padded
    set_config(1'b0, 1'b1, MODE_ENC, 3'd7);
    push_word(8'h81, 1'b1, 4'h0);
    settle();

    // decode: clean, data bit error, last and first parity bit errors, partial tail
    set_config(1'b1, 1'b1, MODE_DEC, 3'd3);
    add_codeword(3, 64'b1011, -1);
    add_codeword(3, 64'b0110, 0);
    add_codeword(3, 64'b1111, 6);
    add_codeword(3, 64'b0000, 4);
    code_bits.push_back(1'b1);
    code_bits.push_back(1'b0);
    code_bits.push_back(1'b1);
    send_code_bits(1'b1);
    // final word with no valid bits and nothing to send
    push_word(8'hC3, 1'b1, 4'h0);
    // valid bit count over eight acts as eight
    push_word(8'hFE, 1'b1, 4'hC);
    settle();

    // random phases, each with its own configuration
    phase = 0;
    while (sent < ITEMS_TARGET) begin
      settle();
      if (phase < 8) begin
        pm = 3'(plan[phase]);
        md = phase[0];
        one_only = 1'b0;
      end else begin
        pm = 3'($urandom_range(0, 7));
        md = $urandom_range(0, 1);
        one_only = ($urandom_range(0, 3) == 0);
      end
      if (one_only && $urandom_range(0, 1) == 1) set_config(1'b1, 1'b0, md, pm);
      else if (one_only) set_config(1'b0, 1'b1, md, pm);
      else set_config(1'b1, 1'b1, md, pm);
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) run_buffer();
      phase++;
    end

    settle();
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
